// ===== rtl/fbd_pkg.sv =====
package fbd_pkg;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_TICK  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      TGT_RAM   = 4'd0,
      TGT_BOOT  = 4'd1,
      TGT_VIA1  = 4'd2,
      TGT_VIA2  = 4'd3,
      TGT_VID   = 4'd4,
      TGT_SND   = 4'd5,
      TGT_VID2  = 4'd6,
      TGT_SD    = 4'd7,
      TGT_LOCAL = 4'd8,
      TGT_NONE  = 4'd9
   } target_type;

   // Where the read data of an access comes from.
   typedef enum logic [1:0] {
      SRC_EXT    = 2'd0,
      SRC_SYSCTL = 2'd1,
      SRC_TIMER  = 2'd2,
      SRC_OPEN   = 2'd3
   } rsrc_type;

   // Configuration register indexes.
   localparam logic CSR_FW_FIRST_BANK = 1'b0;
   localparam logic CSR_CYCLES_PER_MS = 1'b1;

   localparam logic [7:0]  FW_FIRST_BANK_RESET = 8'd240;
   localparam logic [15:0] CYCLES_PER_MS_RESET = 16'd8000;

   // Bank zero address map.
   localparam logic [15:0] IO_BASE     = 16'h9F00;
   localparam logic [15:0] VIA2_BASE   = 16'h9F10;
   localparam logic [15:0] VID_BASE    = 16'h9F20;
   localparam logic [15:0] SND_BASE    = 16'h9F40;
   localparam logic [15:0] SND_END     = 16'h9F50;
   localparam logic [15:0] VID2_BASE   = 16'h9F60;
   localparam logic [15:0] VID2_END    = 16'h9F70;
   localparam logic [15:0] SYSCTL_ADDR = 16'h9F80;
   localparam logic [15:0] SD_END      = 16'h9F90;
   localparam logic [15:0] TIMER_END   = 16'h9F94;
   localparam logic [15:0] IO_END      = 16'hA000;
   localparam logic [15:0] BOOT_BASE   = 16'hFF00;

   typedef struct packed {
      func_type    func;
      logic [7:0]  bank;
      logic [15:0] offset;
      logic [7:0]  wdata;
      logic [7:0]  ext_rdata;
      logic        debug_peek;
      logic        emu_mode;
      logic [7:0]  clocks;
   } req_type;

   typedef struct packed {
      target_type  target;
      logic [23:0] addr;
      logic        strobe;
      rsrc_type    rsrc;
      logic        snd_addr_wr;
      logic        sysctl_wr;
   } dec_type;

endpackage

// ===== rtl/fbd_decode.sv =====
module fbd_decode (
   input  logic             is_write,
   input  logic [7:0]       bank,
   input  logic [15:0]      offset,
   input  logic [7:0]       fw_first_bank,
   input  logic             overlay_on,
   output fbd_pkg::dec_type dec
);
   import fbd_pkg::*;

   always_comb begin
      dec = '{target: TGT_NONE, addr: 24'd0, strobe: 1'b0, rsrc: SRC_OPEN,
              snd_addr_wr: 1'b0, sysctl_wr: 1'b0};
      if (bank != 8'd0) begin
         // Stores into the firmware banks are dropped; reads always go to RAM.
         if (!is_write || (bank < fw_first_bank)) begin
            dec.target = TGT_RAM;
            dec.addr   = {bank, offset};
            dec.strobe = is_write;
            dec.rsrc   = SRC_EXT;
         end
      end else if (offset < IO_BASE) begin
         dec.target = TGT_RAM;
         dec.addr   = {8'd0, offset};
         dec.strobe = is_write;
         dec.rsrc   = SRC_EXT;
      end else if (offset >= IO_END) begin
         if (!is_write && overlay_on && (offset >= BOOT_BASE)) begin
            dec.target = TGT_BOOT;
            dec.addr   = {16'd0, offset[7:0]};
         end else begin
            dec.target = TGT_RAM;
            dec.addr   = {8'd0, offset};
            dec.strobe = is_write;
         end
         dec.rsrc = SRC_EXT;
      end else begin
         priority if (offset < VIA2_BASE) begin
            dec.target = TGT_VIA1;
            dec.addr   = {20'd0, offset[3:0]};
            dec.strobe = is_write;
            dec.rsrc   = SRC_EXT;
         end else if (offset < VID_BASE) begin
            dec.target = TGT_VIA2;
            dec.addr   = {20'd0, offset[3:0]};
            dec.strobe = is_write;
            dec.rsrc   = SRC_EXT;
         end else if (offset < SND_BASE) begin
            dec.target = TGT_VID;
            dec.addr   = {19'd0, offset[4:0]};
            dec.strobe = is_write;
            dec.rsrc   = SRC_EXT;
         end else if (offset < SND_END) begin
            // Even offset is the register address latch, odd is data.
            dec.target      = TGT_SND;
            dec.addr        = {23'd0, offset[0]};
            dec.strobe      = is_write && offset[0];
            dec.snd_addr_wr = is_write && !offset[0];
            dec.rsrc        = SRC_EXT;
         end else if ((offset >= VID2_BASE) && (offset < VID2_END)) begin
            dec.target = TGT_VID2;
            dec.addr   = {20'd0, offset[3:0]};
            dec.strobe = is_write;
            dec.rsrc   = SRC_EXT;
         end else if (offset == SYSCTL_ADDR) begin
            dec.target    = TGT_LOCAL;
            dec.sysctl_wr = is_write;
            dec.rsrc      = SRC_SYSCTL;
         end else if ((offset > SYSCTL_ADDR) && (offset < SD_END)) begin
            dec.target = TGT_SD;
            dec.addr   = {20'd0, offset[3:0]};
            dec.strobe = is_write;
            dec.rsrc   = SRC_EXT;
         end else if ((offset >= SD_END) && (offset < TIMER_END) && !is_write) begin
            // Timer writes are discarded and fall through to no target.
            dec.target = TGT_LOCAL;
            dec.rsrc   = SRC_TIMER;
         end else begin
            dec.target = TGT_NONE;
         end
      end
   end

endmodule

// ===== rtl/fbd_local.sv =====
module fbd_local (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  fbd_pkg::req_type req,
   input  fbd_pkg::dec_type dec,
   input  logic [15:0]      cycles_per_ms,
   output logic             overlay_on,
   output logic [7:0]       rdata,
   output logic [7:0]       sound_reg_addr
);
   import fbd_pkg::*;

   logic        overlay_ff, overlay_in;
   logic [7:0]  open_bus_ff, open_bus_in;
   logic [31:0] ms_count_ff, ms_count_in;
   logic [15:0] accum_ff, accum_in;
   logic [23:0] ms_latch_ff, ms_latch_in;
   logic [7:0]  snd_latch_ff, snd_latch_in;
   logic [16:0] tick_sum;
   logic [16:0] tick_adj;
   logic [7:0]  read_byte;
   logic [7:0]  timer_byte;
   logic        is_read;

   assign is_read = (req.func == FUNC_READ);

   always_comb begin
      unique case (req.offset[1:0])
         2'd0: timer_byte = ms_count_ff[7:0];
         2'd1: timer_byte = ms_latch_ff[7:0];
         2'd2: timer_byte = ms_latch_ff[15:8];
         2'd3: timer_byte = ms_latch_ff[23:16];
         default: timer_byte = ms_count_ff[7:0];
      endcase
      unique case (dec.rsrc)
         SRC_EXT:    read_byte = req.ext_rdata;
         SRC_SYSCTL: read_byte = {6'd0, req.emu_mode, overlay_ff};
         SRC_TIMER:  read_byte = timer_byte;
         SRC_OPEN:   read_byte = open_bus_ff;
         default:    read_byte = open_bus_ff;
      endcase
   end

   assign tick_sum = {1'b0, accum_ff} + {9'd0, req.clocks};
   assign tick_adj = (tick_sum >= {1'b0, cycles_per_ms}) ?
                     (tick_sum - {1'b0, cycles_per_ms}) : tick_sum;

   always_comb begin
      overlay_in   = overlay_ff;
      open_bus_in  = open_bus_ff;
      ms_count_in  = ms_count_ff;
      accum_in     = accum_ff;
      ms_latch_in  = ms_latch_ff;
      snd_latch_in = snd_latch_ff;
      if (fire) begin
         unique case (req.func)
            FUNC_READ: begin
               if (!req.debug_peek) begin
                  open_bus_in = read_byte;
                  if ((dec.rsrc == SRC_TIMER) && (req.offset[1:0] == 2'd0)) begin
                     ms_latch_in = ms_count_ff[31:8];
                  end
               end
            end
            FUNC_WRITE: begin
               open_bus_in = req.wdata;
               if (dec.sysctl_wr) begin
                  overlay_in = req.wdata[0];
               end
               if (dec.snd_addr_wr) begin
                  snd_latch_in = req.wdata;
               end
            end
            FUNC_TICK: begin
               accum_in = tick_adj[15:0];
               if (tick_sum >= {1'b0, cycles_per_ms}) begin
                  ms_count_in = ms_count_ff + 32'd1;
               end
            end
            FUNC_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overlay_ff   <= 1'b1;
         open_bus_ff  <= 8'd0;
         ms_count_ff  <= 32'd0;
         accum_ff     <= 16'd0;
         ms_latch_ff  <= 24'd0;
         snd_latch_ff <= 8'd0;
      end else begin
         overlay_ff   <= overlay_in;
         open_bus_ff  <= open_bus_in;
         ms_count_ff  <= ms_count_in;
         accum_ff     <= accum_in;
         ms_latch_ff  <= ms_latch_in;
         snd_latch_ff <= snd_latch_in;
      end
   end

   assign overlay_on     = overlay_ff;
   assign rdata          = is_read ? read_byte : 8'd0;
   assign sound_reg_addr = snd_latch_in;

endmodule

// ===== rtl/flat_bus_decoder_with_boot_overlay_core.sv =====
// Each accepted request item is registered in the input register, then in the result register,
// which drives its response item. Throughput: one item per cycle while rsp_stall does not hold
// the output; the decode, read select and timer add all settle between the two registers.
// Reset is synchronous and active high: the pipeline empties, the boot overlay
// turns on, the timer, open-bus byte and sound latch clear, and the
// configuration registers return to their defaults.
module flat_bus_decoder_with_boot_overlay_core (
   input  logic        clock,
   input  logic        reset,

   // Configuration write port.
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,

   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_bank,
   input  logic [15:0] req_offset,
   input  logic [7:0]  req_wdata,
   input  logic [7:0]  req_ext_rdata,
   input  logic        req_debug_peek,
   input  logic        req_emu_mode,
   input  logic [7:0]  req_clocks,

   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_target,
   output logic [23:0] rsp_target_addr,
   output logic [7:0]  rsp_rdata,
   output logic        rsp_write_strobe,
   output logic [7:0]  rsp_wdata_out,
   output logic [7:0]  rsp_sound_reg_addr
);
   import fbd_pkg::*;

   // Configuration registers.
   logic [7:0]  fw_first_bank_ff;
   logic [15:0] cycles_per_ms_ff;

   // Input stage.
   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_req_ff;

   // Result stage.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_target_ff;
   logic [23:0] rsp_addr_ff;
   logic [7:0]  rsp_rdata_ff;
   logic        rsp_strobe_ff;
   logic [7:0]  rsp_wdata_ff;
   logic [7:0]  rsp_sound_ff;

   logic        out_free;
   logic        fire;
   logic        req_accept;
   logic        is_access;
   logic        overlay_on;
   logic [7:0]  local_rdata;
   logic [7:0]  local_sound;
   dec_type     dec;

   // The result register frees up when it is empty or is being taken this
   // cycle, so the input stage can move forward while a response drains.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_first_bank_ff <= FW_FIRST_BANK_RESET;
         cycles_per_ms_ff <= CYCLES_PER_MS_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_FW_FIRST_BANK: fw_first_bank_ff <= csr_wdata[7:0];
               CSR_CYCLES_PER_MS: cycles_per_ms_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= '{func: func_type'(req_func), bank: req_bank, offset: req_offset,
                        wdata: req_wdata, ext_rdata: req_ext_rdata,
                        debug_peek: req_debug_peek, emu_mode: req_emu_mode,
                        clocks: req_clocks};
      end
   end

   // Address decode for reads and writes; the write flavor applies the
   // firmware protection and keeps the overlay from catching stores.
   fbd_decode u_decode (
      .is_write      (s1_req_ff.func == FUNC_WRITE),
      .bank          (s1_req_ff.bank),
      .offset        (s1_req_ff.offset),
      .fw_first_bank (fw_first_bank_ff),
      .overlay_on    (overlay_on),
      .dec           (dec)
   );

   // Local registers: system control, open bus, timer and sound latch. They
   // update only when the item leaves the input stage, so items see state in
   // arrival order.
   fbd_local u_local (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .req            (s1_req_ff),
      .dec            (dec),
      .cycles_per_ms  (cycles_per_ms_ff),
      .overlay_on     (overlay_on),
      .rdata          (local_rdata),
      .sound_reg_addr (local_sound)
   );

   // Ticks and the unused function code report no target and zero fields but the sound latch.
   assign is_access = (s1_req_ff.func == FUNC_READ) || (s1_req_ff.func == FUNC_WRITE);

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_target_ff <= is_access ? dec.target : TGT_NONE;
         rsp_addr_ff   <= is_access ? dec.addr : 24'd0;
         rsp_rdata_ff  <= local_rdata;
         rsp_strobe_ff <= (s1_req_ff.func == FUNC_WRITE) && dec.strobe;
         rsp_wdata_ff  <= (s1_req_ff.func == FUNC_WRITE) ? s1_req_ff.wdata : 8'd0;
         rsp_sound_ff  <= local_sound;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target         = rsp_target_ff;
   assign rsp_target_addr    = rsp_addr_ff;
   assign rsp_rdata          = rsp_rdata_ff;
   assign rsp_write_strobe   = rsp_strobe_ff;
   assign rsp_wdata_out      = rsp_wdata_ff;
   assign rsp_sound_reg_addr = rsp_sound_ff;

endmodule

// ===== tb/sv/tb_flat_bus_decoder_with_boot_overlay_core.sv =====
module tb_flat_bus_decoder_with_boot_overlay_core;

   timeunit 1ns;
   timeprecision 1ps;

   import fbd_pkg::*;

   // One decoded bus response, as the block should present it.
   typedef struct packed {
      target_type  target;
      logic [23:0] addr;
      logic [7:0]  rdata;
      logic        strobe;
      logic [7:0]  wdata_out;
      logic [7:0]  sound_addr;
   } bus_result_type;

   logic        clock;
   logic        reset;

   logic        csr_write;
   logic        csr_index;
   logic [15:0] csr_wdata;

   logic        req_valid;
   logic        req_stall;
   req_type     cur_access;

   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_target;
   logic [23:0] rsp_target_addr;
   logic [7:0]  rsp_rdata;
   logic        rsp_write_strobe;
   logic [7:0]  rsp_wdata_out;
   logic [7:0]  rsp_sound_reg_addr;

   // Items waiting to be offered, and responses still owed by the block, oldest first.
   req_type        pending_accesses[$];
   bus_result_type expected_results[$];

   // Shadow copy of the block's architectural state and configuration.
   logic        overlay_enabled;
   logic [7:0]  last_bus_byte;
   logic [31:0] msec_count;
   logic [15:0] cycle_residue;
   logic [23:0] msec_snapshot;
   logic [7:0]  sound_latch;
   logic [7:0]  cfg_fw_bank;
   logic [15:0] cfg_cycles_per_ms;

   // Handshake bookkeeping for the clocked driver, receiver and monitor.
   bit          req_taken;
   bit          rsp_taken;
   int unsigned send_gap;
   int unsigned rsp_wait;
   int unsigned rsp_hold;
   bit          hold_request;
   int unsigned send_idle_max;
   int unsigned recv_idle_max;

   // Run statistics.
   int unsigned failures;
   int unsigned responses_checked;
   int unsigned read_count;
   int unsigned write_count;
   int unsigned tick_count;
   int unsigned other_count;
   int unsigned setting_count;

   flat_bus_decoder_with_boot_overlay_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (cur_access.func),
      .req_bank           (cur_access.bank),
      .req_offset         (cur_access.offset),
      .req_wdata          (cur_access.wdata),
      .req_ext_rdata      (cur_access.ext_rdata),
      .req_debug_peek     (cur_access.debug_peek),
      .req_emu_mode       (cur_access.emu_mode),
      .req_clocks         (cur_access.clocks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_target         (rsp_target),
      .rsp_target_addr    (rsp_target_addr),
      .rsp_rdata          (rsp_rdata),
      .rsp_write_strobe   (rsp_write_strobe),
      .rsp_wdata_out      (rsp_wdata_out),
      .rsp_sound_reg_addr (rsp_sound_reg_addr)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out the response to one accepted item and advances the shadow state
   // exactly as the block does: decode first, then the open-bus and latch updates.
   function automatic bus_result_type predict_bus_result(input req_type acc);
      bus_result_type res;
      logic [15:0]    off;
      logic [16:0]    sum;
      logic [1:0]     timer_byte;
      res.target     = TGT_NONE;
      res.addr       = '0;
      res.rdata      = '0;
      res.strobe     = 1'b0;
      res.wdata_out  = '0;
      off            = acc.offset;
      case (acc.func)
         FUNC_READ: begin
            // Anything not claimed below floats and returns the last bus byte.
            res.rdata = last_bus_byte;
            if (acc.bank != 8'd0) begin
               res.target = TGT_RAM;
               res.addr   = {acc.bank, off};
               res.rdata  = acc.ext_rdata;
            end else if (off < IO_BASE) begin
               res.target = TGT_RAM;
               res.addr   = {8'd0, off};
               res.rdata  = acc.ext_rdata;
            end else if (off < IO_END) begin
               if (off < VIA2_BASE) begin
                  res.target = TGT_VIA1;
                  res.addr   = {20'd0, off[3:0]};
                  res.rdata  = acc.ext_rdata;
               end else if (off < VID_BASE) begin
                  res.target = TGT_VIA2;
                  res.addr   = {20'd0, off[3:0]};
                  res.rdata  = acc.ext_rdata;
               end else if (off < SND_BASE) begin
                  res.target = TGT_VID;
                  res.addr   = {19'd0, off[4:0]};
                  res.rdata  = acc.ext_rdata;
               end else if (off < SND_END) begin
                  res.target = TGT_SND;
                  res.addr   = {23'd0, off[0]};
                  res.rdata  = acc.ext_rdata;
               end else if (off >= VID2_BASE && off < VID2_END) begin
                  res.target = TGT_VID2;
                  res.addr   = {20'd0, off[3:0]};
                  res.rdata  = acc.ext_rdata;
               end else if (off == SYSCTL_ADDR) begin
                  res.target = TGT_LOCAL;
                  res.rdata  = {6'd0, acc.emu_mode, overlay_enabled};
               end else if (off > SYSCTL_ADDR && off < SD_END) begin
                  res.target = TGT_SD;
                  res.addr   = {20'd0, off[3:0]};
                  res.rdata  = acc.ext_rdata;
               end else if (off >= SD_END && off < TIMER_END) begin
                  // Reading the low timer byte freezes the upper three bytes so
                  // that a multi-byte read sees one consistent value.
                  res.target = TGT_LOCAL;
                  timer_byte = off[1:0];
                  if (timer_byte == 2'd0) begin
                     res.rdata = msec_count[7:0];
                     if (!acc.debug_peek) msec_snapshot = msec_count[31:8];
                  end else begin
                     res.rdata = msec_snapshot[8 * (timer_byte - 1) +: 8];
                  end
               end
            end else if (off >= BOOT_BASE && overlay_enabled) begin
               res.target = TGT_BOOT;
               res.addr   = {8'd0, off - BOOT_BASE};
               res.rdata  = acc.ext_rdata;
            end else begin
               res.target = TGT_RAM;
               res.addr   = {8'd0, off};
               res.rdata  = acc.ext_rdata;
            end
            if (!acc.debug_peek) last_bus_byte = res.rdata;
         end
         FUNC_WRITE: begin
            if (acc.bank != 8'd0) begin
               // Firmware banks swallow stores; lower banks are plain RAM.
               if (acc.bank < cfg_fw_bank) begin
                  res.target = TGT_RAM;
                  res.addr   = {acc.bank, off};
                  res.strobe = 1'b1;
               end
            end else if (off < IO_BASE || off >= IO_END) begin
               // The boot overlay is read-only, so its window writes through to RAM.
               res.target = TGT_RAM;
               res.addr   = {8'd0, off};
               res.strobe = 1'b1;
            end else if (off < VIA2_BASE) begin
               res.target = TGT_VIA1;
               res.addr   = {20'd0, off[3:0]};
               res.strobe = 1'b1;
            end else if (off < VID_BASE) begin
               res.target = TGT_VIA2;
               res.addr   = {20'd0, off[3:0]};
               res.strobe = 1'b1;
            end else if (off < SND_BASE) begin
               res.target = TGT_VID;
               res.addr   = {19'd0, off[4:0]};
               res.strobe = 1'b1;
            end else if (off < SND_END) begin
               // Even offsets load the sound chip's register address locally;
               // odd offsets carry the data byte out to the chip.
               res.target = TGT_SND;
               res.addr   = {23'd0, off[0]};
               if (!off[0]) sound_latch = acc.wdata;
               else res.strobe = 1'b1;
            end else if (off >= VID2_BASE && off < VID2_END) begin
               res.target = TGT_VID2;
               res.addr   = {20'd0, off[3:0]};
               res.strobe = 1'b1;
            end else if (off == SYSCTL_ADDR) begin
               res.target      = TGT_LOCAL;
               overlay_enabled = acc.wdata[0];
            end else if (off > SYSCTL_ADDR && off < SD_END) begin
               res.target = TGT_SD;
               res.addr   = {20'd0, off[3:0]};
               res.strobe = 1'b1;
            end
            res.wdata_out = acc.wdata;
            last_bus_byte = acc.wdata;
         end
         FUNC_TICK: begin
            // At most one millisecond per tick, even for tiny divisors.
            sum = {1'b0, cycle_residue} + {9'd0, acc.clocks};
            if (sum >= {1'b0, cfg_cycles_per_ms}) begin
               sum        = sum - {1'b0, cfg_cycles_per_ms};
               msec_count = msec_count + 32'd1;
            end
            cycle_residue = sum[15:0];
         end
         default: ;
      endcase
      res.sound_addr = sound_latch;
      return res;
   endfunction

   task automatic check_field(input string field, input logic [23:0] want,
                              input logic [23:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
      end
   endtask

   // Monitor. Everything is sampled at the rising edge: an accepted request is
   // turned into an expectation right away, so the shadow state always moves
   // in acceptance order, and each accepted response is matched to the oldest one.
   always @(posedge clock) begin
      bus_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_bus_result(cur_access));
            case (cur_access.func)
               FUNC_READ:  read_count++;
               FUNC_WRITE: write_count++;
               FUNC_TICK:  tick_count++;
               default:    other_count++;
            endcase
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            if (expected_results.size() == 0) begin
               failures++;
               $display({"%0t ns: response with none outstanding, expected nothing, ",
                         "actual target 0x%0h"}, $time, rsp_target);
            end else begin
               want = expected_results.pop_front();
               responses_checked++;
               check_field("target",         24'(want.target),     24'(rsp_target));
               check_field("target_addr",    want.addr,            rsp_target_addr);
               check_field("rdata",          24'(want.rdata),      24'(rsp_rdata));
               check_field("write_strobe",   24'(want.strobe),     24'(rsp_write_strobe));
               check_field("wdata_out",      24'(want.wdata_out),  24'(rsp_wdata_out));
               check_field("sound_reg_addr", 24'(want.sound_addr), 24'(rsp_sound_reg_addr));
            end
         end
      end
   end

   // Driver. Inputs move only at the falling edge. After each accepted item the
   // sender draws an idle gap before it offers the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (req_taken) begin
               req_taken = 1'b0;
               send_gap  = $urandom_range(0, send_idle_max);
            end
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               cur_access <= pending_accesses.pop_front();
               req_valid  <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. It draws a stall length after each accepted response. A requested
   // hold-off keeps the response side stalled for a long stretch so the pipeline
   // backs up into the request channel.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_wait  = $urandom_range(0, recv_idle_max);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_hold     = 80;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_access(input func_type fn, input logic [7:0] bank,
                               input logic [15:0] offset, input logic [7:0] wdata,
                               input logic [7:0] ext, input logic peek,
                               input logic emu, input logic [7:0] clocks);
      req_type acc;
      acc.func       = fn;
      acc.bank       = bank;
      acc.offset     = offset;
      acc.wdata      = wdata;
      acc.ext_rdata  = ext;
      acc.debug_peek = peek;
      acc.emu_mode   = emu;
      acc.clocks     = clocks;
      pending_accesses.push_back(acc);
   endtask

   // One random item. Addresses lean toward the I/O page, the local registers,
   // the boot window and the banks around the firmware boundary, since that is
   // where the decode has its corners.
   function automatic req_type random_access(input int unsigned tick_pct);
      req_type     acc;
      int unsigned pick;
      acc.bank       = 8'($urandom_range(0, 255));
      acc.offset     = 16'($urandom_range(0, 65535));
      acc.wdata      = 8'($urandom_range(0, 255));
      acc.ext_rdata  = 8'($urandom_range(0, 255));
      acc.debug_peek = ($urandom_range(0, 3) == 0);
      acc.emu_mode   = 1'($urandom_range(0, 1));
      acc.clocks     = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < tick_pct) acc.func = FUNC_TICK;
      else if (pick < tick_pct + (100 - tick_pct) / 2) acc.func = FUNC_READ;
      else if (pick < 97) acc.func = FUNC_WRITE;
      else acc.func = FUNC_NONE;
      case ($urandom_range(0, 7))
         0, 1: begin
            acc.bank   = 8'd0;
            acc.offset = {8'h9F, acc.offset[7:0]};
         end
         2: begin
            acc.bank   = 8'd0;
            acc.offset = {8'hFF, acc.offset[7:0]};
         end
         3: begin
            acc.bank   = 8'd0;
            acc.offset = ($urandom_range(0, 3) == 0) ? SYSCTL_ADDR
                                                     : {11'h4FC, acc.offset[4:0]};
         end
         4: acc.bank = cfg_fw_bank + 8'($urandom_range(0, 2)) - 8'd1;
         5: acc.bank = 8'd0;
         default: ;
      endcase
      return acc;
   endfunction

   // Mostly single random items, plus the sequences software actually issues:
   // a full four-byte timer read and a sound register address/data pair.
   task automatic queue_random_traffic(input int unsigned count,
                                       input int unsigned tick_pct);
      int unsigned n;
      logic [3:0]  snd_reg;
      n = 0;
      while (n < count) begin
         case ($urandom_range(0, 9))
            0: begin
               queue_access(FUNC_READ, 8'd0, SD_END, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 1'b0,
                            1'($urandom_range(0, 1)), 8'd0);
               for (int b = 1; b < 4; b++)
                  queue_access(FUNC_READ, 8'd0, SD_END + 16'(b),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, 255)));
               n += 4;
            end
            1: begin
               snd_reg = 4'($urandom_range(0, 15));
               queue_access(FUNC_WRITE, 8'd0, SND_BASE | {12'd0, snd_reg[3:1], 1'b0},
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
               queue_access(FUNC_WRITE, 8'd0, SND_BASE | {12'd0, snd_reg[3:1], 1'b1},
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
               n += 2;
            end
            default: begin
               pending_accesses.push_back(random_access(tick_pct));
               n++;
            end
         endcase
      end
   endtask

   // Waits until every queued item has been accepted and answered, then lets
   // the two-stage pipeline settle before anything else happens.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_accesses.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Configuration writes happen only with the block idle, so the shadow copy
   // can follow immediately.
   task automatic write_settings(input logic [7:0] fw_bank, input logic [15:0] cpm);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_FW_FIRST_BANK;
      csr_wdata <= {8'd0, fw_bank};
      @(negedge clock);
      csr_index <= CSR_CYCLES_PER_MS;
      csr_wdata <= cpm;
      @(negedge clock);
      csr_write <= 1'b0;
      cfg_fw_bank       = fw_bank;
      cfg_cycles_per_ms = cpm;
      setting_count++;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] fw_bank, input logic [15:0] cpm,
                            input int unsigned count, input int unsigned tick_pct,
                            input int unsigned send_max, input int unsigned recv_max);
      write_settings(fw_bank, cpm);
      send_idle_max = send_max;
      recv_idle_max = recv_max;
      queue_random_traffic(count, tick_pct);
      wait_drained();
   endtask

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      csr_write  = 1'b0;
      csr_index  = CSR_FW_FIRST_BANK;
      csr_wdata  = '0;
      req_valid  = 1'b0;
      rsp_stall  = 1'b0;
      cur_access = '0;

      overlay_enabled   = 1'b1;
      last_bus_byte     = '0;
      msec_count        = '0;
      cycle_residue     = '0;
      msec_snapshot     = '0;
      sound_latch       = '0;
      cfg_fw_bank       = FW_FIRST_BANK_RESET;
      cfg_cycles_per_ms = CYCLES_PER_MS_RESET;

      send_idle_max = 8;
      recv_idle_max = 8;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass at the reset configuration: address extremes, each
      // target, the boot overlay both ways, sound latch handling, dropped and
      // discarded stores, the timer, peeks and the unused function code.
      queue_access(FUNC_READ,  8'h00, 16'h0000,    8'h00, 8'hFF, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'hFF, 16'hFFFF,    8'hFF, 8'h00, 1'b0, 1'b1, 8'hFF);
      queue_access(FUNC_READ,  8'h00, SYSCTL_ADDR, 8'h00, 8'h5A, 1'b0, 1'b1, 8'h00);
      queue_access(FUNC_READ,  8'h00, BOOT_BASE,   8'h00, 8'h11, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'h00, 16'hFFFF,    8'h00, 8'h22, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_WRITE, 8'h00, 16'hFFFF,    8'hAA, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'h00, VID2_END,    8'h00, 8'h44, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_WRITE, 8'h00, SYSCTL_ADDR, 8'hFE, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'h00, 16'hFF80,    8'h00, 8'h33, 1'b0, 1'b0, 8'h00);
      // The emulator debug device is not there and reads as open bus.
      queue_access(FUNC_READ,  8'h00, 16'h9FB0,    8'h00, 8'h66, 1'b1, 1'b0, 8'h00);
      queue_access(FUNC_WRITE, 8'h00, SND_BASE,    8'h12, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_WRITE, 8'h00, 16'h9F4F,    8'h34, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_WRITE, 8'hF0, 16'h1234,    8'h55, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_WRITE, 8'hEF, 16'hFFFF,    8'h56, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_WRITE, 8'h00, 16'h9F92,    8'h77, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_WRITE, 8'h00, SND_END,     8'h78, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'h00, IO_BASE,     8'h00, 8'h01, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'h00, 16'h9F1F,    8'h00, 8'h02, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'h00, 16'h9F3F,    8'h00, 8'h03, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_WRITE, 8'h00, 16'h9F6F,    8'h04, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'h00, 16'h9F81,    8'h00, 8'h05, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_TICK,  8'h00, 16'h0000,    8'h00, 8'h00, 1'b0, 1'b0, 8'hFF);
      queue_access(FUNC_TICK,  8'h00, 16'h0000,    8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'h00, SD_END,      8'h00, 8'h00, 1'b1, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'h00, SD_END,      8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_READ,  8'h00, 16'h9F93,    8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
      queue_access(FUNC_NONE,  8'hA5, 16'h5A5A,    8'hC3, 8'h3C, 1'b1, 1'b1, 8'h81);
      queue_access(FUNC_WRITE, 8'h00, SYSCTL_ADDR, 8'h01, 8'h00, 1'b0, 1'b0, 8'h00);
      wait_drained();

      // Random phases across several register settings. The divisor of zero
      // makes every tick count, which pushes the timer past its low byte so
      // the latched upper bytes carry real data; one phase runs with no idling.
      run_phase(8'd240, 16'd8000,  150, 10, 8, 8);
      run_phase(8'd0,   16'd0,     400, 70, 8, 8);
      run_phase(8'd255, 16'd65535, 150, 10, 0, 0);
      run_phase(8'd1,   16'd1,     150, 30, 8, 8);
      run_phase(8'($urandom_range(0, 255)), 16'd256, 160, 25, 8, 8);

      // Back-pressure: the receiver holds off for a long stretch while the
      // sender keeps offering items back to back, so the block fills and must
      // stall its request side.
      send_idle_max = 0;
      recv_idle_max = 0;
      hold_request  = 1'b1;
      for (int i = 0; i < 40; i++) pending_accesses.push_back(random_access(10));
      wait_drained();

      repeat (10) @(posedge clock);
      $display("Covered %0d reads, %0d writes, %0d ticks and %0d unused codes",
               read_count, write_count, tick_count, other_count);
      $display("over %0d settings; checked %0d responses, the timer reached %0d ms.",
               setting_count, responses_checked, msec_count);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fbd_pkg.sv
rtl/fbd_decode.sv
rtl/fbd_local.sv
rtl/flat_bus_decoder_with_boot_overlay_core.sv
tb/sv/tb_flat_bus_decoder_with_boot_overlay_core.sv
